### design/dltq_pkg.sv
// Package for the delta-list timer queue: sizes, result codes and the
// entry and token types shared by the cell chain and the top level.
// No dependencies.
package dltq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int DELTA_W     = 16;
  localparam int TAG_W       = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NREL_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_EXPIRED  = 2'd1,
    KIND_REJECTED = 2'd2
  } kind_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // Insert token that walks down the chain. In search mode delta is the
  // remaining delay; in shift mode it carries a displaced entry.
  typedef struct packed {
    logic               valid;
    logic               shift;
    logic [DELTA_W-1:0] delta;
    logic [TAG_W-1:0]   tag;
  } token_t;

endpackage

### design/dltq_req_if.sv
// Request channel of the delta-list timer queue: valid/ready plus payload.
// Depends on nothing but the delay and tag widths below.
interface dltq_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] delay_ticks;
  logic [15:0] task_tag;

  modport source (output valid, operation, delay_ticks, task_tag, input ready);
  modport sink   (input valid, operation, delay_ticks, task_tag, output ready);
endinterface

### design/dltq_rsp_if.sv
// Result channel of the delta-list timer queue: valid/ready plus payload.
// Depends on nothing but the field widths below.
interface dltq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] released_tag;
  logic        last;

  modport source (output valid, kind, released_tag, last, input ready);
  modport sink   (input valid, kind, released_tag, last, output ready);
endinterface

### design/delta_list_timer_queue.sv
// Top level of the delta-list timer queue: cell chain, entry count, expiry
// sequencer and the result register. Depends on dltq_pkg, dltq_cell and the
// dltq_req_if / dltq_rsp_if interfaces.
//
// The queue is a row of QUEUE_DEPTH cells. An insert is answered at once and
// launches a token that walks the chain one cell per clock. The block stays
// busy until the token reaches the first free cell; a full queue is rejected
// without a token. A tick on an empty queue leaves the block idle. Otherwise
// it decrements the head's delta and then releases the expired entries one
// by one, each expiry shifting the whole chain left by one cell. Both wait
// whenever the result register is still held by the sink.
module delta_list_timer_queue
  import dltq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dltq_req_if.sink   req,
  dltq_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_EXPIRE = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [NREL_W-1:0] nrel, nrel_next;

  logic              rsp_valid, rsp_valid_next;
  kind_t             rsp_kind, rsp_kind_next;
  logic [TAG_W-1:0]  rsp_tag, rsp_tag_next;
  logic              rsp_last, rsp_last_next;

  token_t                 tok [QUEUE_DEPTH+1];
  entry_t                 ent [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH-1:0] placed;
  logic [QUEUE_DEPTH:1]   tok_busy;
  logic                   shift_left;
  logic                   dec_head;

  logic accept, full, rsp_free, next_zero, release_now;
  logic [DELTA_W-1:0] want;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign rsp_free = !rsp_valid || rsp.ready;
  assign accept   = req.valid && req.ready;
  assign want     = (req.delay_ticks == '0) ? DELTA_W'(1) : req.delay_ticks;

  assign req.ready = (state == S_IDLE) && (tok_busy == '0) && rsp_free;

  assign tok[0] = '{valid: accept && req.operation && !full, shift: 1'b0,
                    delta: want, tag: req.task_tag};
  assign ent[QUEUE_DEPTH] = '0;

  assign dec_head = accept && !req.operation && (count != '0);

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      dltq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .occupied   (count > CNT_W'(i)),
        .tok_in     (tok[i]),
        .tok_out    (tok[i+1]),
        .nb_in      (ent[i+1]),
        .shift_left (shift_left),
        .dec        ((i == 0) ? dec_head : 1'b0),
        .ent        (ent[i]),
        .placed     (placed[i])
      );
      assign tok_busy[i+1] = tok[i+1].valid;
    end
  endgenerate

  // The head releases while it is due and the per-tick limit is not reached;
  // the neighbor decides whether this release is the last one.
  assign release_now = (count != '0) && (ent[0].delta == '0) &&
                       (nrel < NREL_W'(MAX_RESULTS));
  assign next_zero   = (count > CNT_W'(1)) && (ent[1].delta == '0) &&
                       ((nrel + NREL_W'(1)) < NREL_W'(MAX_RESULTS));

  always_comb begin
    state_next     = state;
    count_next     = count;
    nrel_next      = nrel;
    shift_left     = 1'b0;
    rsp_valid_next = rsp_valid && !rsp.ready;
    rsp_kind_next  = rsp_kind;
    rsp_tag_next   = rsp_tag;
    rsp_last_next  = rsp_last;

    if (placed != '0) begin
      count_next = count + CNT_W'(1);
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.operation) begin
            rsp_valid_next = 1'b1;
            rsp_kind_next  = full ? KIND_REJECTED : KIND_ACCEPTED;
            rsp_tag_next   = req.task_tag;
            rsp_last_next  = 1'b1;
          end else if (count != '0) begin
            nrel_next  = '0;
            state_next = S_EXPIRE;
          end
        end
      end
      S_EXPIRE: begin
        if (rsp_free) begin
          if (release_now) begin
            rsp_valid_next = 1'b1;
            rsp_kind_next  = KIND_EXPIRED;
            rsp_tag_next   = ent[0].tag;
            rsp_last_next  = !next_zero;
            shift_left     = 1'b1;
            count_next     = count - CNT_W'(1);
            nrel_next      = nrel + NREL_W'(1);
            if (!next_zero) begin
              state_next = S_IDLE;
            end
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      nrel      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      nrel      <= nrel_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp_kind <= rsp_kind_next;
    rsp_tag  <= rsp_tag_next;
    rsp_last <= rsp_last_next;
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.kind         = rsp_kind;
  assign rsp.released_tag = rsp_tag;
  assign rsp.last         = rsp_last;

endmodule

### design/dltq_cell.sv
// One slot of the delta-list chain: holds an entry, processes the insert
// token from its left neighbor and hands a registered token to the right.
// Depends on dltq_pkg.
module dltq_cell
  import dltq_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   occupied,
  input  token_t tok_in,
  output token_t tok_out,
  input  entry_t nb_in,
  input  logic   shift_left,
  input  logic   dec,
  output entry_t ent,
  output logic   placed
);

  entry_t ent_next;
  token_t tok_next;

  always_comb begin
    ent_next = ent;
    tok_next = '0;
    placed   = 1'b0;
    if (shift_left) begin
      ent_next = nb_in;
    end else if (dec) begin
      if (ent.delta != '0) begin
        ent_next.delta = ent.delta - DELTA_W'(1);
      end
    end else if (tok_in.valid) begin
      if (!occupied) begin
        ent_next.delta = tok_in.delta;
        ent_next.tag   = tok_in.tag;
        placed         = 1'b1;
      end else if (tok_in.shift) begin
        ent_next.delta = tok_in.delta;
        ent_next.tag   = tok_in.tag;
        tok_next       = '{valid: 1'b1, shift: 1'b1, delta: ent.delta, tag: ent.tag};
      end else if (ent.delta >= tok_in.delta) begin
        // Ties go ahead of this entry, which keeps the remainder of its delta.
        ent_next.delta = tok_in.delta;
        ent_next.tag   = tok_in.tag;
        tok_next       = '{valid: 1'b1, shift: 1'b1,
                           delta: ent.delta - tok_in.delta, tag: ent.tag};
      end else begin
        tok_next = '{valid: 1'b1, shift: 1'b0,
                     delta: tok_in.delta - ent.delta, tag: tok_in.tag};
      end
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule
